[src/rntp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rntp_pkg
// Shared constants and the digit decode for the radix number text parser.
// ----------------------------------------------------------------------------
package rntp_pkg;

  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 16;
  localparam int CNT_W   = 17;
  localparam int DIGIT_W = 7;

  localparam logic [CNT_W-1:0]   COUNT_CAP  = 17'h1FFFF;
  localparam logic [CNT_W-1:0]   COUNT_MAX  = 17'h0FFFF;
  localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0]  BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0]  BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_HEX   = 6'd16;
  localparam logic [DIGIT_W-1:0] NO_DIGIT   = 7'd99;
  localparam logic [DIGIT_W-1:0] HEX_LIMIT  = 7'd16;
  localparam logic [DIGIT_W-1:0] LETTER_OFS = 7'd10;

  localparam logic [VALUE_W-1:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
      d = DIGIT_W'(c - CH_A_LO) + LETTER_OFS;
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      d = DIGIT_W'(c - CH_A_UP) + LETTER_OFS;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[src/radix_number_text_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_number_text_parser_unit
// Streaming ASCII integer parser, one character per item, strtol style.
// ----------------------------------------------------------------------------
// One character item is accepted every cycle. It lands in an input register,
// and one pass of decode plus a 64 by 6 multiply-add updates the parse state.
// On the stopping character the same pass loads the result register, which
// drives out_tvalid, so the result is registered behind the input register.
// The input side stalls only while a result waits in the output register and
// the input register is full. A start flag on in_tuser restarts the parse and
// samples the base register; base 0 detects hex, octal or decimal from the
// prefix, base 16 skips 0x. The value wraps modulo 2^64, the count saturates
// at 65535 and the overflow flag is sticky for the string. Characters after
// the result are dropped until the next start.
// ----------------------------------------------------------------------------
module radix_number_text_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data,   // number_base
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_byte
  input  wire logic        in_tuser,   // first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // value [63:0], consumed_count [79:64]
  output logic             out_tuser   // overflow
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_BODY, PH_ZERO, PH_ZEROX, PH_DIGITS, PH_DONE
  } phase_t;

  localparam int CW = rntp_pkg::CNT_W;
  localparam int VW = rntp_pkg::VALUE_W;
  localparam int BW = rntp_pkg::BASE_W;

  logic [BW-1:0]  number_base_r;
  logic           s1_vld_r;
  logic [7:0]     s1_char_r;
  logic           s1_first_r;
  phase_t         phase_r, phase_nxt;
  logic           neg_r, neg_nxt;
  logic [BW-1:0]  base_r, base_nxt;
  logic [VW-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic           out_vld_r;
  logic [79:0]    out_data_r;
  logic           out_user_r;

  phase_t         ph_e;
  logic           neg_e;
  logic [BW-1:0]  base_e;
  logic [VW-1:0]  acc_e;
  logic [CW-1:0]  cnt_e;
  logic           ovf_e;
  logic           proc;
  logic [6:0]     digit;
  logic [CW-1:0]  cnt_bump;
  logic           go_body;
  logic           use_digit;
  logic [BW-1:0]  tbase;
  logic           digit_ok;
  logic [69:0]    prod;
  logic [70:0]    sum;
  logic [70:0]    limit;
  logic           emit;
  logic [CW-1:0]  emit_cnt;
  logic [VW-1:0]  res_value;
  logic [15:0]    res_count;

  assign proc      = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || proc;
  assign cfg_ready = 1'b1;

  // state seen by the current character: reset on a start flag, else the held state
  always_comb begin
    if (s1_first_r) begin
      ph_e   = PH_LEAD;
      neg_e  = 1'b0;
      base_e = number_base_r;
      acc_e  = '0;
      cnt_e  = '0;
      ovf_e  = 1'b0;
    end else begin
      ph_e   = phase_r;
      neg_e  = neg_r;
      base_e = base_r;
      acc_e  = acc_r;
      cnt_e  = cnt_r;
      ovf_e  = ovf_r;
    end
  end

  assign digit    = rntp_pkg::digit_of(s1_char_r);
  assign cnt_bump = (cnt_e < rntp_pkg::COUNT_CAP) ? cnt_e + 1'b1 : cnt_e;

  // radix for a digit: auto base resolves to octal after a leading zero, else decimal
  assign tbase = (base_e != rntp_pkg::BASE_AUTO) ? base_e :
                 (ph_e == PH_ZERO) ? rntp_pkg::BASE_OCT : rntp_pkg::BASE_DEC;

  always_comb begin
    phase_nxt = ph_e;
    neg_nxt   = neg_e;
    base_nxt  = base_e;
    acc_nxt   = acc_e;
    cnt_nxt   = cnt_e;
    ovf_nxt   = ovf_e;
    go_body   = 1'b0;
    use_digit = 1'b0;
    emit      = 1'b0;
    emit_cnt  = cnt_e;
    case (ph_e)
      PH_LEAD: begin
        if (s1_char_r == rntp_pkg::CH_SPACE || s1_char_r == rntp_pkg::CH_TAB) begin
          cnt_nxt = cnt_bump;
        end else if (s1_char_r == rntp_pkg::CH_MINUS || s1_char_r == rntp_pkg::CH_PLUS) begin
          neg_nxt   = (s1_char_r == rntp_pkg::CH_MINUS);
          cnt_nxt   = cnt_bump;
          phase_nxt = PH_BODY;
        end else begin
          go_body = 1'b1;
        end
      end
      PH_BODY: begin
        go_body = 1'b1;
      end
      PH_ZERO: begin
        if (s1_char_r == rntp_pkg::CH_X_LO || s1_char_r == rntp_pkg::CH_X_UP) begin
          cnt_nxt   = cnt_bump;
          base_nxt  = rntp_pkg::BASE_HEX;
          phase_nxt = PH_ZEROX;
        end else begin
          base_nxt  = tbase;
          use_digit = 1'b1;
        end
      end
      PH_ZEROX: begin
        if (digit < rntp_pkg::HEX_LIMIT) begin
          use_digit = 1'b1;
        end else begin
          emit     = 1'b1;
          emit_cnt = cnt_e - 1'b1;
        end
      end
      PH_DIGITS: begin
        use_digit = 1'b1;
      end
      default: begin
      end
    endcase

    if (go_body) begin
      if ((base_e == rntp_pkg::BASE_AUTO || base_e == rntp_pkg::BASE_HEX)
          && s1_char_r == rntp_pkg::CH_ZERO) begin
        cnt_nxt   = cnt_bump;
        phase_nxt = PH_ZERO;
      end else begin
        base_nxt  = tbase;
        use_digit = 1'b1;
        emit_cnt  = '0;
      end
    end

    if (use_digit) begin
      if (digit_ok) begin
        acc_nxt   = sum[VW-1:0];
        ovf_nxt   = ovf_e || (sum > limit);
        cnt_nxt   = cnt_bump;
        phase_nxt = PH_DIGITS;
      end else begin
        emit = 1'b1;
      end
    end

    if (emit) begin
      phase_nxt = PH_DONE;
    end
  end

  assign digit_ok = (tbase >= rntp_pkg::BASE_MIN) && (tbase <= rntp_pkg::BASE_MAX)
                    && (digit < {1'b0, tbase});
  assign prod  = 70'(acc_e) * 70'(tbase);
  assign sum   = 71'(prod) + 71'(digit);
  assign limit = neg_e ? 71'(rntp_pkg::LIMIT_NEG) : 71'(rntp_pkg::LIMIT_POS);

  assign res_value = neg_e ? (~acc_e + 1'b1) : acc_e;
  assign res_count = (emit_cnt > rntp_pkg::COUNT_MAX) ? 16'hFFFF : emit_cnt[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= rntp_pkg::BASE_RESET;
      s1_vld_r      <= 1'b0;
      s1_first_r    <= 1'b0;
      phase_r       <= PH_IDLE;
      neg_r         <= 1'b0;
      base_r        <= '0;
      acc_r         <= '0;
      cnt_r         <= '0;
      ovf_r         <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        number_base_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        s1_vld_r   <= 1'b1;
        s1_char_r  <= in_tdata;
        s1_first_r <= in_tuser;
      end else if (proc) begin
        s1_vld_r <= 1'b0;
      end
      if (proc && emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (proc) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        ovf_r   <= ovf_nxt;
        if (emit) begin
          out_data_r <= {res_count, res_value};
          out_user_r <= ovf_e;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("input stalled with empty input register");

  a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit) |=> (phase_r == PH_DONE) && out_vld_r)
    else $error("result not loaded or parse not finished");

  a_rose_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(proc && emit))
    else $error("result appeared without a stopping character");

  a_no_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |=> (phase_r != PH_IDLE))
    else $error("parser fell back to idle");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(acc_r) && $stable(cnt_r) && $stable(phase_r))
    else $error("parse state moved without an item");
`endif

endmodule
`default_nettype wire

[verif/tb_radix_number_text_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_number_text_parser_unit
// Self-checking bench for the streaming ASCII integer parser. Directed strings
// cover blanks, signs, prefixes, empty numbers, bad radix values, restarts and
// a write of the base in the middle of a string. Random well-formed strings,
// noise and cut-off strings follow under several base settings. A local parse
// model predicts every result, which is checked field by field in order while
// both the sender and the receiver pause at random.
// ----------------------------------------------------------------------------
module tb_radix_number_text_parser_unit;

  typedef logic [rntp_pkg::CHAR_W-1:0] char_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_BODY, PH_ZERO, PH_ZEROX, PH_DIGITS, PH_DONE
  } parse_phase_t;

  typedef struct {
    logic [rntp_pkg::VALUE_W-1:0] value;
    logic [rntp_pkg::COUNT_W-1:0] count;
    logic                         ovf;
  } parse_result_t;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;   // value [63:0], consumed_count [79:64]
  logic        out_tuser;   // overflow

  // parse model state
  logic [rntp_pkg::BASE_W-1:0]  cfg_base = rntp_pkg::BASE_RESET;
  parse_phase_t                 pr_phase = PH_IDLE;
  logic                         pr_neg = 1'b0;
  logic [rntp_pkg::BASE_W-1:0]  pr_base = '0;
  logic [rntp_pkg::VALUE_W-1:0] pr_acc = '0;
  logic [rntp_pkg::CNT_W-1:0]   pr_count = '0;
  logic                         pr_ovf = 1'b0;

  parse_result_t expected_results[$];

  int  errors = 0;
  int  chars_sent = 0;
  int  active_items = 0;
  int  results_seen = 0;
  int  base_writes = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  pace_gaps = 1'b1;
  int  rx_cycle = 0;
  int  ready_mode = 0;
  bit  hold_active = 1'b0;
  event hold_go;

  radix_number_text_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [rntp_pkg::DIGIT_W-1:0] char_digit(char_t c);
    logic [rntp_pkg::DIGIT_W-1:0] d;
    d = rntp_pkg::NO_DIGIT;
    if (c >= rntp_pkg::CH_A_UP && c <= rntp_pkg::CH_Z_UP) begin
      d = rntp_pkg::DIGIT_W'(c - rntp_pkg::CH_A_UP + rntp_pkg::LETTER_OFS);
    end else if (c >= rntp_pkg::CH_A_LO && c <= rntp_pkg::CH_Z_LO) begin
      d = rntp_pkg::DIGIT_W'(c - rntp_pkg::CH_A_LO + rntp_pkg::LETTER_OFS);
    end else if (c <= rntp_pkg::CH_NINE && c >= rntp_pkg::CH_ZERO) begin
      d = rntp_pkg::DIGIT_W'(c - rntp_pkg::CH_ZERO);
    end
    return d;
  endfunction

  function automatic void count_char();
    if (pr_count < rntp_pkg::COUNT_CAP) begin
      pr_count++;
    end
  endfunction

  function automatic void close_parse(logic [rntp_pkg::CNT_W-1:0] cnt);
    parse_result_t r;
    r.value = pr_neg ? (64'd0 - pr_acc) : pr_acc;
    r.count = (cnt > rntp_pkg::COUNT_MAX) ? rntp_pkg::COUNT_MAX[rntp_pkg::COUNT_W-1:0]
                                          : cnt[rntp_pkg::COUNT_W-1:0];
    r.ovf   = pr_ovf;
    expected_results.push_back(r);
    pr_phase = PH_DONE;
  endfunction

  function automatic void take_digit(char_t c, logic [rntp_pkg::CNT_W-1:0] emit_cnt);
    logic [rntp_pkg::DIGIT_W-1:0] d;
    logic [rntp_pkg::VALUE_W-1:0] b;
    logic [rntp_pkg::VALUE_W-1:0] lim;
    d = char_digit(c);
    b = rntp_pkg::VALUE_W'(pr_base);
    if (pr_base < rntp_pkg::BASE_MIN || pr_base > rntp_pkg::BASE_MAX
        || rntp_pkg::VALUE_W'(d) >= b) begin
      close_parse(emit_cnt);
      return;
    end
    lim = pr_neg ? rntp_pkg::LIMIT_NEG : rntp_pkg::LIMIT_POS;
    if (!pr_ovf && pr_acc > (lim - rntp_pkg::VALUE_W'(d)) / b) begin
      pr_ovf = 1'b1;
    end
    pr_acc = pr_acc * b + rntp_pkg::VALUE_W'(d);
    count_char();
    pr_phase = PH_DIGITS;
  endfunction

  function automatic void body_char(char_t c);
    if ((pr_base == rntp_pkg::BASE_AUTO || pr_base == rntp_pkg::BASE_HEX)
        && c == rntp_pkg::CH_ZERO) begin
      count_char();
      pr_phase = PH_ZERO;
    end else begin
      if (pr_base == rntp_pkg::BASE_AUTO) begin
        pr_base = rntp_pkg::BASE_DEC;
      end
      take_digit(c, '0);
    end
  endfunction

  // returns 0 when the parser drops the character
  function automatic bit model_char(char_t c, bit first);
    if (first) begin
      pr_phase = PH_LEAD;
      pr_neg   = 1'b0;
      pr_base  = cfg_base;
      pr_acc   = '0;
      pr_count = '0;
      pr_ovf   = 1'b0;
    end else if (pr_phase == PH_IDLE || pr_phase == PH_DONE) begin
      return 1'b0;
    end
    case (pr_phase)
      PH_LEAD: begin
        if (c == rntp_pkg::CH_SPACE || c == rntp_pkg::CH_TAB) begin
          count_char();
        end else if (c == rntp_pkg::CH_MINUS || c == rntp_pkg::CH_PLUS) begin
          pr_neg = (c == rntp_pkg::CH_MINUS);
          count_char();
          pr_phase = PH_BODY;
        end else begin
          body_char(c);
        end
      end
      PH_BODY: begin
        body_char(c);
      end
      PH_ZERO: begin
        if (c == rntp_pkg::CH_X_LO || c == rntp_pkg::CH_X_UP) begin
          count_char();
          pr_base  = rntp_pkg::BASE_HEX;
          pr_phase = PH_ZEROX;
        end else begin
          if (pr_base == rntp_pkg::BASE_AUTO) begin
            pr_base = rntp_pkg::BASE_OCT;
          end
          take_digit(c, pr_count);
        end
      end
      PH_ZEROX: begin
        if (char_digit(c) < rntp_pkg::HEX_LIMIT) begin
          take_digit(c, pr_count);
        end else begin
          close_parse(pr_count - 1'b1);
        end
      end
      PH_DIGITS: begin
        take_digit(c, pr_count);
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 20) begin
      $display("mismatch at cycle %0d, %s: got %h expected %h", cycle_count, what,
               got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", out_tdata[63:0], '0);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (out_tdata[63:0] !== want.value) begin
          report_mismatch("value", out_tdata[63:0], want.value);
        end
        if (out_tdata[79:64] !== want.count) begin
          report_mismatch("consumed_count", 64'(out_tdata[79:64]), 64'(want.count));
        end
        if (out_tuser !== want.ovf) begin
          report_mismatch("overflow", 64'(out_tuser), 64'(want.ovf));
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 160 == 0) begin
      ready_mode = $urandom_range(0, 3);
    end
    if (hold_active) begin
      out_tready = 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 1) != 0);
        2: out_tready = (rx_cycle % 7) > 2;
        default: out_tready = ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always begin
    @(hold_go);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active = 1'b0;
  end

  // ---------------------------------------------------------------- sender

  task automatic send_char(char_t c, bit first);
    int gap;
    if (pace_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tuser  = first;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
    if (model_char(c, first)) begin
      active_items++;
    end
  endtask

  task automatic send_literal(string s, bit add_term, char_t term);
    for (int i = 0; i < s.len(); i++) begin
      send_char(char_t'(s[i]), i == 0);
    end
    if (add_term) begin
      send_char(term, s.len() == 0);
    end
  endtask

  task automatic wait_parser_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic [5:0] b);
    wait_parser_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = b;
    do @(posedge clk); while (!cfg_ready);
    cfg_base = b;
    base_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic char_t digit_char(int d);
    if (d < 10) begin
      return rntp_pkg::CH_ZERO + char_t'(d);
    end
    return ($urandom_range(0, 1) ? rntp_pkg::CH_A_LO : rntp_pkg::CH_A_UP)
           + char_t'(d - 10);
  endfunction

  task automatic send_random_string(logic [5:0] base);
    char_t text[$];
    int mode;
    int radix;
    int k;
    int n;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // noise, mostly without a start flag
      repeat ($urandom_range(1, 6)) begin
        send_char(char_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      return;
    end
    repeat ($urandom_range(0, 5) == 0 ? $urandom_range(3, 6) : $urandom_range(0, 1)) begin
      text.push_back($urandom_range(0, 1) ? rntp_pkg::CH_SPACE : rntp_pkg::CH_TAB);
    end
    k = $urandom_range(0, 3);
    if (k == 1) begin
      text.push_back(rntp_pkg::CH_MINUS);
    end else if (k == 2) begin
      text.push_back(rntp_pkg::CH_PLUS);
    end
    if (base == rntp_pkg::BASE_AUTO) begin
      radix = 10;
    end else if (base >= rntp_pkg::BASE_MIN && base <= rntp_pkg::BASE_MAX) begin
      radix = int'(base);
    end else begin
      radix = 36;
    end
    k = $urandom_range(0, 3);
    if (base == rntp_pkg::BASE_AUTO || base == rntp_pkg::BASE_HEX) begin
      if (k == 1) begin
        text.push_back(rntp_pkg::CH_ZERO);
        text.push_back($urandom_range(0, 1) ? rntp_pkg::CH_X_LO : rntp_pkg::CH_X_UP);
        radix = 16;
      end else if (k == 2) begin
        text.push_back(rntp_pkg::CH_ZERO);
        if (base == rntp_pkg::BASE_AUTO) begin
          radix = 8;
        end
      end
    end else if (k == 1) begin
      text.push_back(rntp_pkg::CH_ZERO);
    end
    if ($urandom_range(0, 11) == 0) begin
      n = 0;
    end else if ($urandom_range(0, 8) == 0) begin
      n = $urandom_range(15, 70);
    end else begin
      n = $urandom_range(1, 6);
    end
    repeat (n) text.push_back(digit_char($urandom_range(0, radix - 1)));
    // mode 1 leaves the string open, the next start cuts it off
    if (mode != 1) begin
      text.push_back($urandom_range(0, 1) ? char_t'(0) : char_t'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) text.push_back(char_t'($urandom_range(0, 255)));
    end
    foreach (text[i]) begin
      send_char(text[i], i == 0);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_ignored_before_start();
    send_char(rntp_pkg::CH_ZERO + 8'd7, 1'b0);
    send_char(8'h00, 1'b0);
  endtask

  task automatic test_sign_and_blanks();
    send_literal(" \t-42", 1'b1, 8'h00);
    send_char(rntp_pkg::CH_ZERO + 8'd9, 1'b0);
  endtask

  task automatic test_no_digits();
    send_literal("+x", 1'b0, 8'h00);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_prefixes();
    write_base(rntp_pkg::BASE_AUTO);
    send_literal("0x1F", 1'b1, ";");
    send_literal("017", 1'b1, 8'h00);
    send_literal("0", 1'b1, 8'h00);
    send_literal("9z", 1'b0, 8'h00);
    write_base(rntp_pkg::BASE_HEX);
    send_literal("0xg", 1'b0, 8'h00);
    send_literal("0X7f", 1'b1, 8'h00);
  endtask

  task automatic test_invalid_base();
    write_base(6'd1);
    send_literal(" +5", 1'b0, 8'h00);
    write_base(6'd63);
    send_literal("z", 1'b0, 8'h00);
  endtask

  task automatic test_mid_string_config();
    write_base(rntp_pkg::BASE_DEC);
    send_literal("12", 1'b0, 8'h00);
    write_base(rntp_pkg::BASE_HEX);
    send_char(rntp_pkg::CH_A_LO, 1'b0);
    send_literal("ff", 1'b1, 8'h00);
  endtask

  task automatic test_restart();
    send_literal("12", 1'b0, 8'h00);
    send_literal("3", 1'b1, 8'h00);
  endtask

  task automatic test_overflow_edges();
    write_base(rntp_pkg::BASE_DEC);
    send_literal("9223372036854775807", 1'b1, 8'h00);
    send_literal("-9223372036854775808", 1'b1, 8'h00);
    send_literal("9223372036854775808", 1'b1, 8'h00);
    write_base(6'd36);
    send_literal("-zzzzzzzzzzzzz", 1'b1, 8'h00);
  endtask

  task automatic test_backpressure();
    pace_gaps = 1'b0;
    write_base(rntp_pkg::BASE_DEC);
    -> hold_go;
    repeat (40) begin
      send_char(digit_char($urandom_range(0, 9)), 1'b1);
      send_char(8'h00, 1'b0);
    end
    pace_gaps = 1'b1;
  endtask

  task automatic test_random_strings();
    logic [5:0] bases[10];
    int start;
    bases = '{rntp_pkg::BASE_DEC, rntp_pkg::BASE_AUTO, rntp_pkg::BASE_HEX,
              rntp_pkg::BASE_MIN, rntp_pkg::BASE_MAX, rntp_pkg::BASE_OCT,
              6'd1, 6'd37, 6'd63, 6'd10};
    bases[9] = 6'($urandom_range(2, 36));
    foreach (bases[i]) begin
      pace_gaps = (i % 3 != 2);
      write_base(bases[i]);
      start = chars_sent;
      while (chars_sent - start < PHASE_ITEMS) begin
        send_random_string(bases[i]);
      end
    end
    pace_gaps = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ignored_before_start();
    test_sign_and_blanks();
    test_no_digits();
    test_prefixes();
    test_invalid_base();
    test_mid_string_config();
    test_restart();
    test_overflow_edges();
    test_backpressure();
    test_random_strings();

    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 64'(expected_results.size()), '0);
    end

    $display("%0d characters sent, %0d parsed, %0d results checked, %0d mismatches",
             chars_sent, active_items, results_seen, errors);
    $display("covered blanks, signs, prefixes, bad radix values, restarts, %0d base %s",
             base_writes, "writes and a long output stall");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
